[src/lsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_pkg: shared types and constants
// Pattern sizes, register indexes, configuration bundle and byte folding.
// ----------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

  localparam int PATTERN_MAX   = 32;
  localparam int PATTERN_WORDS = 4;
  localparam int WORD_W        = 64;
  localparam int WORD_BYTES    = WORD_W / 8;
  localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
  localparam int CFG_LEN_W     = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int LINE_NUM_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_31 = 3'd3,
    REG_PAT_LEN   = 3'd4,
    REG_FOLD_CASE = 3'd5
  } lsm_reg_t;

  typedef struct packed {
    logic [PATTERN_WORDS-1:0][WORD_W-1:0] words;
    logic [CFG_LEN_W-1:0]                 length;
    logic                                 fold_case;
  } lsm_cfg_t;

  // Lowercase A to Z when folding is on.
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/lsm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_if: channel interfaces
// Text byte requests, line result requests and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_end;
  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

interface lsm_out_if;
  logic                             valid;
  logic                             ready;
  logic                             line_matched;
  logic [lsm_pkg::LINE_NUM_W-1:0]   line_number;
  modport source (output valid, output line_matched, output line_number, input ready);
  modport sink   (input valid, input line_matched, input line_number, output ready);
endinterface

interface lsm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lsm_pkg::CFG_IDX_W-1:0]   index;
  logic [lsm_pkg::WORD_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/lsm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_front: byte intake and window match
// Shifts each byte into the window, compares all positions in parallel and
// pushes one found flag per finished line into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lsm_pkg::lsm_cfg_t cfg_regs,
  lsm_in_if.sink                 text_in,
  input  wire logic              q_full,
  output logic                   q_push,
  output logic                   q_data
);
  import lsm_pkg::*;

  logic [7:0]       window [PATTERN_MAX];
  logic [7:0]       win_next [PATTERN_MAX];
  logic [7:0]       pat_byte [PATTERN_MAX];
  logic [7:0]       aligned [PATTERN_MAX];
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] count;
  logic [LEN_W-1:0] count_next;
  logic             found;
  logic             found_next;
  logic             hit;
  logic             match;
  logic             accept;

  assign text_in.ready = !q_full;
  assign accept        = text_in.valid && text_in.ready;

  // Clamp the length to the window size.
  assign len_eff = (cfg_regs.length > CFG_LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                               : LEN_W'(cfg_regs.length);

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (k < PATTERN_WORDS * WORD_BYTES) begin
        pat_byte[k] = fold_byte(cfg_regs.words[k / WORD_BYTES][(k % WORD_BYTES) * 8 +: 8],
                                cfg_regs.fold_case);
      end else begin
        pat_byte[k] = 8'h00;
      end
    end
  end

  // Window slot j holds the byte that must equal pattern byte len-1-j.
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      aligned[j] = 8'h00;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if ((k + j + 1) == int'(len_eff)) begin
          aligned[j] = pat_byte[k];
        end
      end
    end
  end

  always_comb begin
    win_next[0] = fold_byte(text_in.text_byte, cfg_regs.fold_case);
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_next[i] = window[i-1];
    end
  end

  assign count_next = (count < LEN_W'(PATTERN_MAX)) ? count + LEN_W'(1) : count;

  always_comb begin
    hit = 1'b1;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (j < int'(len_eff) && win_next[j] != aligned[j]) begin
        hit = 1'b0;
      end
    end
  end

  assign match      = (len_eff == '0) || ((count_next >= len_eff) && hit);
  assign found_next = found || match;

  assign q_push = accept && text_in.line_end;
  assign q_data = found_next;

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        window[i] <= win_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      found <= 1'b0;
    end else if (accept) begin
      // Drop per-line state at the end of a line.
      if (text_in.line_end) begin
        count <= '0;
        found <= 1'b0;
      end else begin
        count <= count_next;
        found <= found_next;
      end
    end
  end

endmodule

`default_nettype wire

[src/lsm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_queue: two-entry line result queue
// Decouples the byte intake from the result output.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire logic push_data,
  output logic      full,
  input  wire logic pop,
  output logic      pop_valid,
  output logic      pop_data
);
  import lsm_pkg::*;

  logic [1:0] entries;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full      = (fill == 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[src/lsm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_back: line numbering and result register
// Counts finished lines with saturation and holds the outgoing result.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire logic q_data,
  output logic      q_pop,
  lsm_out_if.source line_out
);
  import lsm_pkg::*;

  logic [LINE_NUM_W-1:0] line_counter;
  logic [LINE_NUM_W-1:0] line_counter_next;
  logic                  out_valid;
  logic                  out_matched;
  logic [LINE_NUM_W-1:0] out_number;

  assign q_pop = q_valid && (!out_valid || line_out.ready);

  assign line_counter_next = (line_counter == '1) ? line_counter
                                                  : line_counter + LINE_NUM_W'(1);

  assign line_out.valid        = out_valid;
  assign line_out.line_matched = out_matched;
  assign line_out.line_number  = out_number;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_matched <= q_data;
      out_number  <= line_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        line_counter <= line_counter_next;
        out_valid    <= 1'b1;
      end else if (line_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/line_substring_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_substring_matcher: streaming per-line substring search
// Reports, for every line of a byte stream, whether the configured pattern
// occurs in it, together with the line's saturating number.
// ----------------------------------------------------------------------------
// A line result passes from the front through the line queue and then the
// result register before it turns valid on line_out.
// Throughput: one text byte request per cycle while the line queue has room,
// with all window positions compared in parallel; one line result per cycle out while line_out is ready.
// Back-pressure on the result side stalls the text side only once the
// two-entry line queue and the result register are full.
// Reset (rst, synchronous) clears the configuration to zero, the line
// counter, the per-line state and the queue; no clearing pass is needed.
`default_nettype none

module line_substring_matcher (
  input  wire logic clk,
  input  wire logic rst,
  lsm_in_if.sink    text_in,
  lsm_out_if.source line_out,
  lsm_cfg_if.sink   cfg
);
  import lsm_pkg::*;

  lsm_cfg_t cfg_regs;
  logic     q_push;
  logic     q_push_data;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  logic     q_data;

  // Configuration writes are always taken; indexes past the list are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PAT_0_7:   cfg_regs.words[0]  <= cfg.data;
        REG_PAT_8_15:  cfg_regs.words[1]  <= cfg.data;
        REG_PAT_16_23: cfg_regs.words[2]  <= cfg.data;
        REG_PAT_24_31: cfg_regs.words[3]  <= cfg.data;
        REG_PAT_LEN:   cfg_regs.length    <= cfg.data[CFG_LEN_W-1:0];
        REG_FOLD_CASE: cfg_regs.fold_case <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // Front: take bytes, update the window and the per-line found flag.
  lsm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .text_in  (text_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  // Hold finished-line flags so either side can stall on its own.
  lsm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  // Back: number the line and present the result request.
  lsm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .line_out (line_out)
  );

endmodule

`default_nettype wire
